>>> rtl/core/cds_pkg.sv
package cds_pkg;

    localparam int OFFSET_BITS = 21;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int STAT_W  = 2;

    // tdata packing: year, month, day, then the signed offset on the input side
    localparam int DATE_W     = YEAR_W + MONTH_W + DAY_W;
    localparam int S_DATA_W   = ((DATE_W + OFFSET_BITS + 7) / 8) * 8;
    localparam int M_DATA_W   = ((DATE_W + 7) / 8) * 8;
    localparam int YEAR_LO    = 0;
    localparam int MONTH_LO   = YEAR_W;
    localparam int DAY_LO     = YEAR_W + MONTH_W;
    localparam int OFFSET_LO  = DATE_W;

    // working day count: offset plus up to one year of days, with sign
    localparam int ACC_W = ((OFFSET_BITS > 10) ? OFFSET_BITS : 10) + 2;

    localparam logic [YEAR_W-1:0]  MAX_YEAR    = 14'd9999;
    localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd2020;
    localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd2;
    localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd2;
    localparam logic [MONTH_W-1:0] LAST_MONTH  = 4'd12;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SHIFT = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_RANGE   = 2'd2;

    localparam logic [DAY_W-1:0] BASE_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // multiplicative inverse of 25 modulo 2**14, and the divisibility bound
    localparam logic [YEAR_W-1:0] INV25     = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV25_MAX = 14'd655;

    localparam logic [8:0] DAYS_YEAR = 9'd365;
    localparam logic [8:0] DAYS_LEAP = 9'd366;

    typedef struct packed {
        logic capture;
        logic init_shift;
        logic doy_add;
        logic year_dec;
        logic year_add;
        logic year_inc;
        logic month_start;
        logic month_sub;
        logic set_err;
        logic finish;
    } cds_cmd_t;

    typedef struct packed {
        logic cmd_shift;
        logic wm_lt_cur;
        logic neg;
        logic ge_ylen;
        logic ge_mlen;
        logic wy_min;
        logic wy_max;
        logic out_free;
    } cds_stat_t;

    // leap: divisible by 4 and not by 100, or by 400 (100 = 4*25, 400 = 16*25)
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [2*YEAR_W-1:0] prod;
        logic                div25;
        prod  = y * INV25;
        div25 = (prod[YEAR_W-1:0] <= DIV25_MAX);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] n;
        n = '0;
        if (m >= 4'd1 && m <= LAST_MONTH)
        begin
            n = BASE_LEN[4'(m - 4'd1)];
            if (m == 4'd2 && leap)
            begin
                n = n + 5'd1;
            end
        end
        return n;
    endfunction

endpackage

>>> rtl/core/cds_datapath.sv
module cds_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [cds_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         s_tuser,
    input  cds_pkg::cds_cmd_t            cmd,
    output cds_pkg::cds_stat_t           stat,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [cds_pkg::M_DATA_W-1:0] m_tdata,
    output logic [cds_pkg::STAT_W-1:0]   m_tuser
);
    import cds_pkg::*;

    // current date
    logic [YEAR_W-1:0]  year_reg;
    logic [MONTH_W-1:0] month_reg;
    logic [DAY_W-1:0]   day_reg;

    // captured transaction
    logic                   cmd_reg;
    logic [YEAR_W-1:0]      ly_reg;
    logic [MONTH_W-1:0]     lm_reg;
    logic [DAY_W-1:0]       ld_reg;
    logic [OFFSET_BITS-1:0] off_reg;

    // working registers of a shift
    logic [YEAR_W-1:0]  wy_reg;
    logic [MONTH_W-1:0] wm_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic               err_reg;

    // result register
    logic               out_valid_reg;
    logic [YEAR_W-1:0]  out_year_reg;
    logic [MONTH_W-1:0] out_month_reg;
    logic [DAY_W-1:0]   out_day_reg;
    logic [STAT_W-1:0]  out_stat_reg;

    logic             wy_leap;
    logic [DAY_W-1:0] mlen;
    logic [8:0]       ylen;
    logic [ACC_W-1:0] mlen_x;
    logic [ACC_W-1:0] ylen_x;
    logic [ACC_W-1:0] init_acc;
    logic             load_ok;
    logic [DAY_W-1:0] load_mlen;

    assign wy_leap = is_leap(wy_reg);
    assign mlen    = month_len(wy_leap, wm_reg);
    assign ylen    = wy_leap ? DAYS_LEAP : DAYS_YEAR;
    assign mlen_x  = {{(ACC_W-DAY_W){1'b0}}, mlen};
    assign ylen_x  = {{(ACC_W-9){1'b0}}, ylen};

    // day-of-year index starts from the day within the month, months added later
    assign init_acc = {{(ACC_W-OFFSET_BITS){off_reg[OFFSET_BITS-1]}}, off_reg}
                    + {{(ACC_W-DAY_W){1'b0}}, day_reg - 5'd1};

    assign load_mlen = month_len(is_leap(ly_reg), lm_reg);
    assign load_ok   = (ly_reg != '0) && (ly_reg <= MAX_YEAR)
                    && (lm_reg >= 4'd1) && (lm_reg <= LAST_MONTH)
                    && (ld_reg != '0) && (ld_reg <= load_mlen);

    always_comb
    begin
        stat.cmd_shift = (cmd_reg == CMD_SHIFT);
        stat.wm_lt_cur = (wm_reg < month_reg);
        stat.neg       = acc_reg[ACC_W-1];
        stat.ge_ylen   = !acc_reg[ACC_W-1] && (acc_reg >= ylen_x);
        stat.ge_mlen   = !acc_reg[ACC_W-1] && (acc_reg >= mlen_x) && (wm_reg < LAST_MONTH);
        stat.wy_min    = (wy_reg == 14'd1);
        stat.wy_max    = (wy_reg == MAX_YEAR);
        stat.out_free  = !out_valid_reg || m_tready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg <= s_tuser;
            ly_reg  <= s_tdata[YEAR_LO +: YEAR_W];
            lm_reg  <= s_tdata[MONTH_LO +: MONTH_W];
            ld_reg  <= s_tdata[DAY_LO +: DAY_W];
            off_reg <= s_tdata[OFFSET_LO +: OFFSET_BITS];
        end

        if (cmd.init_shift)
        begin
            wy_reg  <= year_reg;
            wm_reg  <= 4'd1;
            acc_reg <= init_acc;
        end
        else if (cmd.doy_add)
        begin
            acc_reg <= acc_reg + mlen_x;
            wm_reg  <= wm_reg + 4'd1;
        end
        else if (cmd.year_dec)
        begin
            wy_reg <= wy_reg - 14'd1;
        end
        else if (cmd.year_add)
        begin
            acc_reg <= acc_reg + ylen_x;
        end
        else if (cmd.year_inc)
        begin
            acc_reg <= acc_reg - ylen_x;
            wy_reg  <= wy_reg + 14'd1;
        end
        else if (cmd.month_start)
        begin
            wm_reg <= 4'd1;
        end
        else if (cmd.month_sub)
        begin
            acc_reg <= acc_reg - mlen_x;
            wm_reg  <= wm_reg + 4'd1;
        end

        if (cmd.finish)
        begin
            if (cmd_reg == CMD_LOAD)
            begin
                if (load_ok)
                begin
                    out_year_reg  <= ly_reg;
                    out_month_reg <= lm_reg;
                    out_day_reg   <= ld_reg;
                    out_stat_reg  <= STATUS_OK;
                end
                else
                begin
                    out_year_reg  <= year_reg;
                    out_month_reg <= month_reg;
                    out_day_reg   <= day_reg;
                    out_stat_reg  <= STATUS_INVALID;
                end
            end
            else if (err_reg)
            begin
                out_year_reg  <= year_reg;
                out_month_reg <= month_reg;
                out_day_reg   <= day_reg;
                out_stat_reg  <= STATUS_RANGE;
            end
            else
            begin
                out_year_reg  <= wy_reg;
                out_month_reg <= wm_reg;
                out_day_reg   <= acc_reg[DAY_W-1:0] + 5'd1;
                out_stat_reg  <= STATUS_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg      <= RESET_YEAR;
            month_reg     <= RESET_MONTH;
            day_reg       <= RESET_DAY;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.init_shift)
            begin
                err_reg <= 1'b0;
            end
            else if (cmd.set_err)
            begin
                err_reg <= 1'b1;
            end

            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                if (cmd_reg == CMD_LOAD && load_ok)
                begin
                    year_reg  <= ly_reg;
                    month_reg <= lm_reg;
                    day_reg   <= ld_reg;
                end
                else if (cmd_reg == CMD_SHIFT && !err_reg)
                begin
                    year_reg  <= wy_reg;
                    month_reg <= wm_reg;
                    day_reg   <= acc_reg[DAY_W-1:0] + 5'd1;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-DATE_W){1'b0}}, out_day_reg, out_month_reg, out_year_reg};
    assign m_tuser  = out_stat_reg;

endmodule

>>> rtl/core/cds_ctrl.sv
module cds_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  cds_pkg::cds_stat_t stat,
    output cds_pkg::cds_cmd_t  cmd
);
    import cds_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_INIT   = 7'b0000010,
        ST_DOY    = 7'b0000100,
        ST_YEAR   = 7'b0001000,
        ST_YBACK  = 7'b0010000,
        ST_MONTH  = 7'b0100000,
        ST_FINISH = 7'b1000000
    } cds_state_t;

    cds_state_t state_reg;
    cds_state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (stat.cmd_shift)
                begin
                    cmd.init_shift = 1'b1;
                    state_next     = ST_DOY;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            // fold the months before the current one into the day count
            ST_DOY:
            begin
                if (stat.wm_lt_cur)
                begin
                    cmd.doy_add = 1'b1;
                end
                else
                begin
                    state_next = ST_YEAR;
                end
            end
            // walk whole years until the count lands inside one
            ST_YEAR:
            begin
                priority if (stat.neg)
                begin
                    if (stat.wy_min)
                    begin
                        cmd.set_err = 1'b1;
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        cmd.year_dec = 1'b1;
                        state_next   = ST_YBACK;
                    end
                end
                else if (stat.ge_ylen)
                begin
                    if (stat.wy_max)
                    begin
                        cmd.set_err = 1'b1;
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        cmd.year_inc = 1'b1;
                    end
                end
                else
                begin
                    cmd.month_start = 1'b1;
                    state_next      = ST_MONTH;
                end
            end
            ST_YBACK:
            begin
                cmd.year_add = 1'b1;
                state_next   = ST_YEAR;
            end
            ST_MONTH:
            begin
                if (stat.ge_mlen)
                begin
                    cmd.month_sub = 1'b1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/core/calendar_date_shift.sv
// Gregorian date register with load and day shift.
// Input stream (s_*): s_tuser is the command (0 load, 1 shift); s_tdata carries
// load_year, load_month, load_day and the signed day_offset. Each transaction
// gives exactly one result on the output stream (m_*): the current date after
// the step in m_tdata and a status in m_tuser (0 ok, 1 invalid load date,
// 2 year out of range; on a nonzero status the date is left as it was).
// A load passes from the init state to the finish state, which registers the
// result and raises m_tvalid; the block takes its next item only when it is
// back in the idle state. A shift then folds in the months before the current
// one, walks the years crossed and subtracts the months into the target year;
// the year walk in the controller moves one year per cycle forward, and each
// year backward goes through the extra state ST_YBACK.
// One transaction is in work at a time; s_tready is high whenever the block
// is idle, even while a result still waits in the output register.
// If m_tready is held low, a finished result waits until the output register
// is free. Reset sets the date to 2020-02-02 and empties the output register.
module calendar_date_shift (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // load_year, load_month, load_day, day_offset, zero fill
    input  logic [cds_pkg::S_DATA_W-1:0] s_tdata,
    // command
    input  logic                         s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // out_year, out_month, out_day, zero fill
    output logic [cds_pkg::M_DATA_W-1:0] m_tdata,
    // status
    output logic [cds_pkg::STAT_W-1:0]   m_tuser
);
    import cds_pkg::*;

    cds_cmd_t  cmd;
    cds_stat_t stat;

    cds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cds_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> rtl/core/cds_checker.sv
module cds_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [cds_pkg::M_DATA_W-1:0] m_tdata,
    input logic [cds_pkg::STAT_W-1:0]   m_tuser
);
    import cds_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // every result shows a nonzero year up to the maximum, a month in 1..12, a nonzero day and a defined status
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == STATUS_OK || m_tuser == STATUS_INVALID
                      || m_tuser == STATUS_RANGE)
                  && m_tdata[YEAR_LO +: YEAR_W] != '0
                  && m_tdata[YEAR_LO +: YEAR_W] <= MAX_YEAR
                  && m_tdata[MONTH_LO +: MONTH_W] != '0
                  && m_tdata[MONTH_LO +: MONTH_W] <= LAST_MONTH
                  && m_tdata[DAY_LO +: DAY_W] != '0)
        else $error("result date out of range");

    // one transaction in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted a second transaction while busy");

    // an accepted load or shift does not raise m_tvalid at once when no result was waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

endmodule

bind calendar_date_shift cds_checker u_cds_checker (.*);

>>> verif/tb_calendar_date_shift.sv
module tb_calendar_date_shift;
    import cds_pkg::*;

    localparam longint DAYS_PER_400Y = 146097;
    localparam longint DAYS_PER_100Y = 36524;
    localparam longint DAYS_PER_4Y   = 1461;
    localparam longint DAYS_PER_Y    = 365;
    localparam int     RANDOM_ITEMS  = 114;
    localparam int     DRAIN_CYCLES  = 20;

    typedef struct {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [STAT_W-1:0]  status;
    } date_result_t;

    class date_scoreboard;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        date_result_t       pending[$];
        int                 errors;
        int                 month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

        function new();
            year   = RESET_YEAR;
            month  = RESET_MONTH;
            day    = RESET_DAY;
            errors = 0;
        endfunction

        function bit leap_year(int y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        // m must be 1..12
        function int days_in_month(int y, int m);
            return month_days[m - 1] + ((m == 2 && leap_year(y)) ? 1 : 0);
        endfunction

        // 0001-01-01 is day zero
        function longint day_number(int y, int m, int d);
            longint p;
            longint n;
            p = y - 1;
            n = p * DAYS_PER_Y + p / 4 - p / 100 + p / 400;
            for (int k = 1; k < m; k++)
                n += days_in_month(y, k);
            return n + d - 1;
        endfunction

        function void set_from_day_number(longint n);
            longint q400;
            longint q100;
            longint q4;
            longint q1;
            longint r;
            int     y;
            int     m;
            q400 = n / DAYS_PER_400Y;
            r    = n % DAYS_PER_400Y;
            // the last day of a 400 or 4 year cycle belongs to the final century or year
            q100 = r / DAYS_PER_100Y;
            if (q100 > 3)
                q100 = 3;
            r  -= q100 * DAYS_PER_100Y;
            q4  = r / DAYS_PER_4Y;
            r   = r % DAYS_PER_4Y;
            q1  = r / DAYS_PER_Y;
            if (q1 > 3)
                q1 = 3;
            r -= q1 * DAYS_PER_Y;
            y  = int'(q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1);
            m  = 1;
            while (m < 12 && r >= days_in_month(y, m))
            begin
                r -= days_in_month(y, m);
                m++;
            end
            year  = YEAR_W'(y);
            month = MONTH_W'(m);
            day   = DAY_W'(r + 1);
        endfunction

        function void note_input(logic cmd, logic [S_DATA_W-1:0] data);
            date_result_t exp_res;
            int           ly;
            int           lm;
            int           ld;
            longint       target;
            exp_res.status = STATUS_OK;
            if (cmd == CMD_LOAD)
            begin
                ly = int'(data[YEAR_LO +: YEAR_W]);
                lm = int'(data[MONTH_LO +: MONTH_W]);
                ld = int'(data[DAY_LO +: DAY_W]);
                if (ly >= 1 && ly <= int'(MAX_YEAR) && lm >= 1 && lm <= int'(LAST_MONTH)
                    && ld >= 1 && ld <= days_in_month(ly, lm))
                begin
                    year  = YEAR_W'(ly);
                    month = MONTH_W'(lm);
                    day   = DAY_W'(ld);
                end
                else
                begin
                    exp_res.status = STATUS_INVALID;
                end
            end
            else
            begin
                target = day_number(year, month, day)
                       + longint'($signed(data[OFFSET_LO +: OFFSET_BITS]));
                if (target < 0 || target > day_number(MAX_YEAR, 12, 31))
                    exp_res.status = STATUS_RANGE;
                else
                    set_from_day_number(target);
            end
            exp_res.year  = year;
            exp_res.month = month;
            exp_res.day   = day;
            pending.push_back(exp_res);
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data, logic [STAT_W-1:0] stat);
            date_result_t exp_res;
            date_result_t got;
            got.year   = data[YEAR_LO +: YEAR_W];
            got.month  = data[MONTH_LO +: MONTH_W];
            got.day    = data[DAY_LO +: DAY_W];
            got.status = stat;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %0d-%0d-%0d status %0d", $time,
                         got.year, got.month, got.day, got.status);
                return;
            end
            exp_res = pending.pop_front();
            if (got.year !== exp_res.year || got.month !== exp_res.month
                || got.day !== exp_res.day || got.status !== exp_res.status)
            begin
                errors++;
                $display("%0t: expected %0d-%0d-%0d status %0d, actual %0d-%0d-%0d status %0d",
                         $time, exp_res.year, exp_res.month, exp_res.day, exp_res.status,
                         got.year, got.month, got.day, got.status);
            end
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [STAT_W-1:0]     m_tuser;

    date_scoreboard sb;
    bit             send_burst;
    bit             recv_burst;

    calendar_date_shift dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // one transaction on the input side; valid stays high between back-to-back items
    task automatic send_item(logic cmd, logic [S_DATA_W-1:0] data);
        int gap;
        if ($urandom_range(0, 15) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(cmd, data);
    endtask

    task automatic send_load(int y, int m, int d);
        logic [S_DATA_W-1:0] data;
        data = '0;
        data[YEAR_LO +: YEAR_W]        = YEAR_W'(y);
        data[MONTH_LO +: MONTH_W]      = MONTH_W'(m);
        data[DAY_LO +: DAY_W]          = DAY_W'(d);
        // offset is don't-care on a load
        data[OFFSET_LO +: OFFSET_BITS] = OFFSET_BITS'($urandom());
        send_item(CMD_LOAD, data);
    endtask

    task automatic send_shift(int off);
        logic [S_DATA_W-1:0] data;
        data = '0;
        data[YEAR_LO +: YEAR_W]        = YEAR_W'($urandom());
        data[MONTH_LO +: MONTH_W]      = MONTH_W'($urandom());
        data[DAY_LO +: DAY_W]          = DAY_W'($urandom());
        data[OFFSET_LO +: OFFSET_BITS] = OFFSET_BITS'(off);
        send_item(CMD_SHIFT, data);
    endtask

    task automatic send_valid_load(int y);
        int m;
        m = $urandom_range(1, 12);
        send_load(y, m, $urandom_range(1, sb.days_in_month(y, m)));
    endtask

    // result side
    initial
    begin
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                recv_burst = !recv_burst;
            gap = recv_burst ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            sb.check_result(m_tdata, m_tuser);
        end
    end

    initial
    begin
        int sel;
        int kind;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_LOAD;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset date, leap rules, month-length edges, calendar limits
        send_shift(0);
        send_load(2020, 2, 29);
        send_load(1900, 2, 29);
        send_load(2000, 2, 29);
        send_shift(1);
        send_load(0, 1, 1);
        send_load(16383, 15, 31);
        send_load(10000, 1, 1);
        send_load(2023, 0, 10);
        send_load(2023, 13, 10);
        send_load(2023, 4, 31);
        send_load(2023, 4, 0);
        send_load(2023, 1, 31);
        send_shift(1);
        send_load(2100, 2, 28);
        send_shift(1);
        send_load(9999, 12, 31);
        send_shift(1);
        send_shift(-1048576);
        send_load(1, 1, 1);
        send_shift(-1);
        send_shift(1048575);
        send_shift(-1048576);
        send_load(2024, 12, 31);
        send_shift(1);
        send_shift(-1);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 15)
            begin
                // half ordinary years, half pinned near the calendar ends
                kind = $urandom_range(0, 3);
                if (kind == 0)
                    send_valid_load($urandom_range(1, 3));
                else if (kind == 1)
                    send_valid_load($urandom_range(9997, 9999));
                else
                    send_valid_load($urandom_range(1, 9999));
            end
            else if (sel < 22)
            begin
                send_load($urandom_range(0, 16383), $urandom_range(0, 15),
                          $urandom_range(0, 31));
            end
            else if (sel < 70)
            begin
                send_shift(int'($urandom_range(0, 800)) - 400);
            end
            else if (sel < 88)
            begin
                send_shift(int'($urandom_range(0, 200000)) - 100000);
            end
            else
            begin
                send_shift(int'($urandom()));
            end
        end
        s_tvalid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> calendar_date_shift.f
rtl/core/cds_pkg.sv
rtl/core/cds_datapath.sv
rtl/core/cds_ctrl.sv
rtl/core/calendar_date_shift.sv
rtl/core/cds_checker.sv
verif/tb_calendar_date_shift.sv
